/* rtl/uled_pkg.sv */
// Shared types, constants and the command text table for the UART LED command decoder.
// No dependencies; every other file in rtl/ imports this package.
package uled_pkg;

    localparam int          DEFAULT_COUNT_WIDTH = 24;
    localparam int          CFG_W               = 24;
    localparam logic [23:0] BLINK_HALF_RESET    = 24'd2000001;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam int         POS_W   = 4;
    localparam logic [3:0] POS_MAX = 4'd15;

    localparam int NUM_CMDS    = 6;
    localparam int CMD_MAX_LEN = 11;

    localparam logic [NUM_CMDS-1:0] ALIVE_ALL = '1;

    // Command text, first character in the top byte, padded with blanks to the
    // longest command. Characters past a command's length are never compared.
    // The closing carriage return is written as an octal escape.
    localparam logic [8*CMD_MAX_LEN-1:0] CMD_STR [NUM_CMDS] = '{
        "LED1 ON\015   ",
        "LED1 OFF\015  ",
        "LED2 ON\015   ",
        "LED2 OFF\015  ",
        "LED1 BLINK\015",
        "LED2 BLINK\015"
    };

    localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{
        4'd8, 4'd9, 4'd8, 4'd9, 4'd11, 4'd11
    };

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_LED1_ON    = 3'd1,
        CMD_LED1_OFF   = 3'd2,
        CMD_LED2_ON    = 3'd3,
        CMD_LED2_OFF   = 3'd4,
        CMD_LED1_BLINK = 3'd5,
        CMD_LED2_BLINK = 3'd6
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t command_code;
        logic      line_done;
        logic      led2_level;
        logic      led1_level;
    } result_t;

    typedef struct packed {
        logic advance;
        logic restart;
    } blink_ctrl_t;

    function automatic logic [7:0] cmd_char(input int k, input logic [3:0] pos);
        int idx;
        idx = int'(pos);
        if (idx < CMD_MAX_LEN) begin
            return CMD_STR[k][(CMD_MAX_LEN - 1 - idx) * 8 +: 8];
        end
        return 8'h00;
    endfunction

endpackage

/* rtl/uled_blink.sv */
// Blink timer for one LED: tick counter and phase bit.
// Depends on uled_pkg for the control struct and the register width.
module uled_blink #(
    parameter int COUNT_WIDTH = uled_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  uled_pkg::blink_ctrl_t      ctrl,
    input  logic [uled_pkg::CFG_W-1:0] half_period,
    output logic                       phase_next
);
    import uled_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH + 1 > CFG_W) ? COUNT_WIDTH + 1 : CFG_W;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   phase_reg;
    logic [COUNT_WIDTH:0]   count_inc;
    logic [CFG_W-1:0]       period_nz;
    logic                   wrap;

    assign count_inc = {1'b0, count_reg} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    assign period_nz = (half_period == '0) ? CFG_W'(1) : half_period;
    // A full counter always wraps, which limits the half period to 2^COUNT_WIDTH ticks.
    assign wrap = (CMP_W'(count_inc) >= CMP_W'(period_nz)) || (&count_reg);

    always_comb begin
        count_next = count_reg;
        phase_next = phase_reg;
        if (ctrl.restart) begin
            count_next = '0;
            phase_next = 1'b1;
        end else if (ctrl.advance) begin
            if (wrap) begin
                count_next = '0;
                phase_next = ~phase_reg;
            end else begin
                count_next = count_inc[COUNT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            phase_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

endmodule

/* rtl/uled_out_buf.sv */
// Two-entry output buffer (output register plus skid register) for result words.
// Depends on uled_pkg for the result word type.
module uled_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  uled_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output uled_pkg::result_t out_data
);
    import uled_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        // Pop first; the skid word moves up into the output register.
        if (out_valid_reg && out_ready) begin
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (in_valid && !skid_valid_reg) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

/* rtl/uart_led_command_decoder.sv */
// Top level of the UART LED command decoder: line matcher, LED flags and output channel.
// Depends on uled_pkg, uled_blink and uled_out_buf.
//
//  channel | signals                             | word
//  --------+-------------------------------------+--------------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser   | tuser byte_valid; tdata rx_byte, tick
//  m_      | m_tvalid m_tready m_tdata m_tlast   | tlast line_done; tdata levels, code
//  cfg_    | cfg_valid cfg_ready cfg_data        | blink_half_period
//
// One input word is accepted per cycle unless input stalls; its result word is registered in
// the output buffer. Matching, LED flags and blink timers update in the accept cycle.
// A two-entry output buffer keeps input flowing while one result waits; input stalls
// only when both entries are full. Reset is synchronous and active low, with no clearing pass.
module uart_led_command_decoder #(
    parameter int COUNT_WIDTH = uled_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [8] tick, [15:9] zero
    input  logic        s_tuser,   // [0] byte_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] led1_level, [1] led2_level, [4:2] command_code
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data
);
    import uled_pkg::*;

    logic [CFG_W-1:0]    half_period_reg;
    logic [POS_W-1:0]    line_pos_reg, line_pos_next;
    logic [NUM_CMDS-1:0] alive_reg, alive_next;
    logic                prev_cr_reg, prev_cr_next;
    logic [1:0]          on_reg, on_next;
    logic [1:0]          blink_reg, blink_next;
    logic [1:0]          restart;
    logic [1:0]          phase_next;
    blink_ctrl_t         blink_ctrl [2];

    logic       in_fire;
    logic [7:0] rx_byte;
    logic       tick;
    logic       byte_ok;
    logic       line_end;
    cmd_code_t  code;
    result_t    result;
    result_t    out_word;

    assign rx_byte  = s_tdata[7:0];
    assign tick     = s_tdata[8];
    assign in_fire  = s_tvalid && s_tready;
    assign byte_ok  = s_tuser && (rx_byte != 8'h00);
    assign line_end = byte_ok && (rx_byte == CHAR_LF) && prev_cr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= BLINK_HALF_RESET;
        end else if (cfg_valid && cfg_ready) begin
            half_period_reg <= cfg_data;
        end
    end

    // The first command whose prefix is still alive at its full length wins.
    always_comb begin
        code = CMD_NONE;
        for (int k = NUM_CMDS - 1; k >= 0; k--) begin
            if (alive_reg[k] && (line_pos_reg == CMD_LEN[k])) begin
                code = cmd_code_t'(3'(k + 1));
            end
        end
    end

    always_comb begin
        line_pos_next = line_pos_reg;
        alive_next    = alive_reg;
        prev_cr_next  = prev_cr_reg;
        on_next       = on_reg;
        blink_next    = blink_reg;
        restart       = 2'b00;
        if (byte_ok) begin
            if (line_end) begin
                line_pos_next = '0;
                alive_next    = ALIVE_ALL;
                prev_cr_next  = 1'b0;
                case (code)
                    CMD_LED1_ON: begin
                        on_next[0]    = 1'b1;
                        blink_next[0] = 1'b0;
                    end
                    CMD_LED2_ON: begin
                        on_next[1]    = 1'b1;
                        blink_next[1] = 1'b0;
                    end
                    CMD_LED1_OFF: begin
                        on_next[0]    = 1'b0;
                        blink_next[0] = 1'b0;
                    end
                    CMD_LED2_OFF: begin
                        on_next[1]    = 1'b0;
                        blink_next[1] = 1'b0;
                    end
                    CMD_LED1_BLINK: begin
                        on_next[0]    = 1'b0;
                        blink_next[0] = 1'b1;
                        restart[0]    = 1'b1;
                    end
                    CMD_LED2_BLINK: begin
                        on_next[1]    = 1'b0;
                        blink_next[1] = 1'b1;
                        restart[1]    = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end else begin
                for (int k = 0; k < NUM_CMDS; k++) begin
                    if ((line_pos_reg >= CMD_LEN[k]) || (cmd_char(k, line_pos_reg) != rx_byte)) begin
                        alive_next[k] = 1'b0;
                    end
                end
                if (line_pos_reg < POS_MAX) begin
                    line_pos_next = line_pos_reg + 4'd1;
                end
                prev_cr_next = (rx_byte == CHAR_CR);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_pos_reg <= '0;
            alive_reg    <= ALIVE_ALL;
            prev_cr_reg  <= 1'b0;
            on_reg       <= 2'b00;
            blink_reg    <= 2'b00;
        end else if (in_fire) begin
            line_pos_reg <= line_pos_next;
            alive_reg    <= alive_next;
            prev_cr_reg  <= prev_cr_next;
            on_reg       <= on_next;
            blink_reg    <= blink_next;
        end
    end

    // The tick acts on the blink flags as they were before this word's command.
    for (genvar g = 0; g < 2; g++) begin : g_blink
        assign blink_ctrl[g].advance = in_fire && tick && blink_reg[g];
        assign blink_ctrl[g].restart = in_fire && restart[g];

        uled_blink #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_blink (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (blink_ctrl[g]),
            .half_period(half_period_reg),
            .phase_next (phase_next[g])
        );
    end

    always_comb begin
        result.led1_level   = blink_next[0] ? phase_next[0] : on_next[0];
        result.led2_level   = blink_next[1] ? phase_next[1] : on_next[1];
        result.line_done    = line_end;
        result.command_code = line_end ? code : CMD_NONE;
    end

    uled_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (result),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_word)
    );

    assign m_tdata = {3'b000, out_word.command_code, out_word.led2_level, out_word.led1_level};
    assign m_tlast = out_word.line_done;

`ifndef SYNTHESIS
    a_code_only_on_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[4:2] == CMD_NONE))
        else $error("command code set on a word that does not end a line");

    a_line_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && line_end) |=> ((alive_reg == ALIVE_ALL) && (line_pos_reg == '0) && !prev_cr_reg))
        else $error("line state not cleared after a line end");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && line_end && (code != CMD_NONE)) |=> ((on_reg & blink_reg) == 2'b00))
        else $error("an LED is both on and blinking after a command");

    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");
`endif

endmodule

/* tb/led_command_checker.sv */
// Scoreboard for the UART LED command decoder: predicts every result word and checks it.
// Depends on uled_pkg for the command code enum and the CR and LF characters.
module led_command_checker
    import uled_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [23:0] cfg_data,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [23:0] PERIOD_AT_RESET = 24'd2000001;

    typedef struct packed {
        logic      led1;
        logic      led2;
        logic      done;
        cmd_code_t code;
    } led_result_t;

    // Command text without the closing CR, which every command carries as its last character.
    string     cmd_body [NUM_CMDS] = '{"LED1 ON", "LED1 OFF", "LED2 ON", "LED2 OFF",
                                       "LED1 BLINK", "LED2 BLINK"};
    cmd_code_t cmd_of [NUM_CMDS]   = '{CMD_LED1_ON, CMD_LED1_OFF, CMD_LED2_ON, CMD_LED2_OFF,
                                       CMD_LED1_BLINK, CMD_LED2_BLINK};

    logic [23:0]         half_period;
    logic [3:0]          line_pos;
    logic [NUM_CMDS-1:0] alive;
    logic                after_cr;
    logic [1:0]          on_flags;
    logic [1:0]          blink_flags;
    logic [23:0]         blink_cnt [2];
    logic [1:0]          blink_lvl;
    led_result_t         expected_levels [$];
    int                  err_count = 0;

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    function automatic led_result_t decode_word(input logic byte_valid, input logic [7:0] rx,
                                                input logic tick);
        led_result_t r;
        logic [24:0] period;
        logic [24:0] nxt;
        logic [7:0]  want_ch;
        int          clen;
        int          led;
        logic        found;
        r      = '0;
        r.code = CMD_NONE;
        found  = 1'b0;
        // The tick is applied before the byte.
        if (tick) begin
            period = (half_period == 24'd0) ? 25'd1 : {1'b0, half_period};
            for (int i = 0; i < 2; i++) begin
                if (blink_flags[i]) begin
                    nxt = {1'b0, blink_cnt[i]} + 25'd1;
                    if (nxt >= period) begin
                        blink_cnt[i] = '0;
                        blink_lvl[i] = ~blink_lvl[i];
                    end else begin
                        blink_cnt[i] = nxt[23:0];
                    end
                end
            end
        end
        if (byte_valid && rx != 8'h00) begin
            if (rx == CHAR_LF && after_cr) begin
                r.done = 1'b1;
                for (int k = 0; k < NUM_CMDS; k++) begin
                    clen = cmd_body[k].len() + 1;
                    if (!found && alive[k] && int'(line_pos) == clen) begin
                        r.code = cmd_of[k];
                        found  = 1'b1;
                    end
                end
                led = (r.code == CMD_LED2_ON || r.code == CMD_LED2_OFF ||
                       r.code == CMD_LED2_BLINK) ? 1 : 0;
                case (r.code)
                    CMD_LED1_ON, CMD_LED2_ON: begin
                        on_flags[led]    = 1'b1;
                        blink_flags[led] = 1'b0;
                    end
                    CMD_LED1_OFF, CMD_LED2_OFF: begin
                        on_flags[led]    = 1'b0;
                        blink_flags[led] = 1'b0;
                    end
                    CMD_LED1_BLINK, CMD_LED2_BLINK: begin
                        on_flags[led]    = 1'b0;
                        blink_flags[led] = 1'b1;
                        blink_cnt[led]   = '0;
                        blink_lvl[led]   = 1'b1;
                    end
                    default: begin
                    end
                endcase
                line_pos = '0;
                alive    = '1;
                after_cr = 1'b0;
            end else begin
                for (int k = 0; k < NUM_CMDS; k++) begin
                    clen = cmd_body[k].len() + 1;
                    if (int'(line_pos) >= clen) begin
                        alive[k] = 1'b0;
                    end else begin
                        want_ch = (int'(line_pos) < cmd_body[k].len()) ? cmd_body[k][line_pos]
                                                                       : CHAR_CR;
                        if (want_ch != rx) alive[k] = 1'b0;
                    end
                end
                if (line_pos != 4'd15) line_pos = line_pos + 4'd1;
                after_cr = (rx == CHAR_CR);
            end
        end
        r.led1 = blink_flags[0] ? blink_lvl[0] : on_flags[0];
        r.led2 = blink_flags[1] ? blink_lvl[1] : on_flags[1];
        return r;
    endfunction

    always @(posedge aclk) begin
        led_result_t want;
        if (!aresetn) begin
            half_period = PERIOD_AT_RESET;
            line_pos    = '0;
            alive       = '1;
            after_cr    = 1'b0;
            on_flags    = '0;
            blink_flags = '0;
            blink_cnt   = '{24'd0, 24'd0};
            blink_lvl   = '0;
            expected_levels.delete();
        end else begin
            if (cfg_valid && cfg_ready) half_period = cfg_data;
            // A result word never leaves in the cycle its input word is accepted, so check first.
            if (m_tvalid && m_tready) begin
                if (expected_levels.size() == 0) begin
                    report_mismatch("unexpected result word", int'(m_tdata), 0);
                end else begin
                    want = expected_levels.pop_front();
                    if (m_tdata[0] !== want.led1)
                        report_mismatch("led1_level", int'(m_tdata[0]), int'(want.led1));
                    if (m_tdata[1] !== want.led2)
                        report_mismatch("led2_level", int'(m_tdata[1]), int'(want.led2));
                    if (m_tlast !== want.done)
                        report_mismatch("line_done", int'(m_tlast), int'(want.done));
                    if (m_tdata[4:2] !== want.code)
                        report_mismatch("command_code", int'(m_tdata[4:2]), int'(want.code));
                    if (m_tdata[7:5] !== 3'd0)
                        report_mismatch("tdata padding", int'(m_tdata[7:5]), 0);
                end
            end
            if (s_tvalid && s_tready)
                expected_levels.push_back(decode_word(s_tuser, s_tdata[7:0], s_tdata[8]));
        end
        mismatches <= err_count;
        pending    <= expected_levels.size();
    end

endmodule

/* tb/tb.sv */
// Testbench top for the UART LED command decoder: clock, reset, stimulus and verdict.
// Depends on uled_pkg, the decoder RTL and led_command_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uled_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data  = '0;

    int          mismatches;
    int          pending;
    int          hold_requests = 0;
    int          sent_bytes    = 0;
    int          tick_pct      = 50;
    int          idle_cycles   = 0;
    bit          mix_ignored   = 1'b0;
    bit          sender_calm   = 1'b0;
    logic [7:0]  line_buf [$];
    logic [23:0] phase_period [8] = '{24'd1, 24'd2, 24'hFFFFFF, 24'd3, 24'd1, 24'd6, 24'd1,
                                      24'd4};
    string       cmd_body [NUM_CMDS] = '{"LED1 ON", "LED1 OFF", "LED2 ON", "LED2 OFF",
                                         "LED1 BLINK", "LED2 BLINK"};

    uart_led_command_decoder i_dut (.*);

    led_command_checker i_checker (.*);

    always begin
        #4;
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
    end

    // Receiver: random calm stretches and stretches of random stalls, plus a long hold when requested.
    initial begin : receiver
        int stall_left;
        int calm_left;
        int holds_done;
        bit calm;
        stall_left = 0;
        calm_left  = 0;
        holds_done = 0;
        calm       = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_done) begin
                holds_done = hold_requests;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                if (calm_left == 0) begin
                    calm      = ($urandom_range(0, 2) == 0);
                    calm_left = $urandom_range(30, 150);
                end
                calm_left--;
                if (!calm && $urandom_range(0, 99) < 25) begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
                    m_tready <= 1'b0;
                    stall_left--;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_word(input logic byte_valid, input logic [7:0] rx);
        int gap;
        int r;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, ($urandom_range(0, 99) < tick_pct), rx};
        s_tuser  <= byte_valid;
        do @(posedge aclk); while (!s_tready);
        gap = 0;
        if (!sender_calm) begin
            r = $urandom_range(0, 99);
            if (r >= 96) gap = $urandom_range(8, 40);
            else if (r >= 70) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_period(input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic add_body(input int k);
        for (int i = 0; i < cmd_body[k].len(); i++) line_buf.push_back(cmd_body[k][i]);
    endtask

    // Mostly well-formed command lines, the rest damaged lines and raw noise.
    task automatic build_line();
        int k;
        int r;
        int n;
        line_buf.delete();
        k = $urandom_range(0, NUM_CMDS - 1);
        r = $urandom_range(0, 99);
        if (r < 60) begin
            add_body(k);
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_LF);
        end else if (r < 68) begin
            add_body(k);
            line_buf.push_back(CHAR_CR);
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(1, 255));
            line_buf.push_back(CHAR_LF);
        end else if (r < 74) begin
            add_body(k);
            n = $urandom_range(0, line_buf.size() - 1);
            while (line_buf.size() > n) void'(line_buf.pop_back());
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_LF);
        end else if (r < 79) begin
            add_body(k);
            line_buf.push_back(8'($urandom_range(32, 126)));
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_LF);
        end else if (r < 84) begin
            // Longer than any command, so none matches; the longer of these lines saturate the position.
            repeat ($urandom_range(12, 20)) line_buf.push_back(8'($urandom_range(1, 255)));
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_LF);
        end else if (r < 88) begin
            add_body(k);
            line_buf.insert($urandom_range(0, line_buf.size()), CHAR_LF);
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_LF);
        end else if (r < 92) begin
            add_body(k);
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_LF);
        end else if (r < 96) begin
            add_body(k);
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(8'($urandom_range(1, 255)));
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_LF);
        end else begin
            repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic push_line();
        foreach (line_buf[i]) begin
            if (mix_ignored && $urandom_range(0, 99) < 8) begin
                if ($urandom_range(0, 1) == 0) send_word(1'b0, 8'($urandom_range(0, 255)));
                else send_word(1'b1, 8'h00);
            end
            send_word(1'b1, line_buf[i]);
            if (line_buf[i] != 8'h00) sent_bytes++;
        end
        sender_calm = ($urandom_range(0, 3) == 0);
    endtask

    initial begin : stimulus
        int  phase_start;
        bit  held;
        bit  paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under the reset half period.
        send_word(1'b0, 8'hA5);
        send_word(1'b1, 8'h00);
        send_word(1'b1, CHAR_LF);
        send_word(1'b1, CHAR_CR);
        send_word(1'b1, CHAR_LF);
        send_word(1'b1, CHAR_CR);
        send_word(1'b1, CHAR_LF);
        send_word(1'b1, 8'hFF);
        send_word(1'b1, CHAR_CR);
        send_word(1'b1, CHAR_LF);
        line_buf.delete();
        add_body(NUM_CMDS - 1);
        line_buf.push_back(CHAR_CR);
        line_buf.push_back(CHAR_LF);
        push_line();

        phase_period[6] = 24'($urandom_range(1, 12));
        mix_ignored     = 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            write_period(phase_period[ph]);
            tick_pct    = $urandom_range(15, 95);
            phase_start = sent_bytes;
            while (sent_bytes - phase_start < 135) begin
                // A long receiver hold-off while words keep coming fills the output buffer.
                if (ph == 1 && !held && sent_bytes - phase_start >= 40) begin
                    hold_requests++;
                    held = 1'b1;
                end
                if (ph == 4 && !paused && sent_bytes - phase_start >= 60) begin
                    wait_drained();
                    paused = 1'b1;
                end
                build_line();
                push_line();
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
